>>> sv/first_fit_heap_allocator_top_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define FFHA_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define FFHA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> sv/ffha_pkg.sv
// Types, constants and codes shared by the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned MAX_BLOCKS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned HDR_BYTES  = 40;
  localparam int unsigned SPLIT_MIN  = 32;
  localparam int unsigned ALIGN_B    = 8;
  localparam logic [31:0] RST_HSIZE  = 32'd65536;
  localparam logic [31:0] RST_BSIZE  = RST_HSIZE - 32'(HDR_BYTES);

  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_SIZE = 1'b1;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NULL   = 3'd1;
  localparam logic [2:0] ST_NOHEAP = 3'd2;
  localparam logic [2:0] ST_BAD    = 3'd3;
  localparam logic [2:0] ST_DOUBLE = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] request_size;
    logic [47:0] release_address;
  } req_t;

  typedef struct packed {
    logic [47:0] address;
    logic [2:0]  status;
    logic [31:0] used_bytes;
    logic [31:0] free_bytes;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_TAKE,
    CMD_SPLIT,
    CMD_FREE,
    CMD_MERGE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      need;
    logic [31:0]      new_start;
    logic [31:0]      new_size;
    logic [31:0]      init_size;
  } cmd_t;

  typedef struct packed {
    logic        alloc;
    logic [33:0] need;
    logic [47:0] ptr_off;
  } key_t;

endpackage

>>> sv/ffha_cell.sv
// One table entry of the allocator: holds a block and matches it against the key.
module ffha_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ffha_pkg::IDX_W-1:0] idx_i,
  input  ffha_pkg::cmd_t        cmd_i,
  input  ffha_pkg::key_t        key_i,
  input  logic [ffha_pkg::CNT_W-1:0] count_i,
  input  ffha_pkg::entry_t      left_i,
  input  ffha_pkg::entry_t      right_i,
  output ffha_pkg::entry_t      entry_o,
  output logic                  hit_o
);
  import ffha_pkg::*;

  entry_t ent_q, ent_d;
  logic [CNT_W-1:0] me, tgt, tgt_nx;
  logic valid;

  assign me     = CNT_W'(idx_i);
  assign tgt    = CNT_W'(cmd_i.idx);
  assign tgt_nx = tgt + CNT_W'(1);
  assign valid  = me < count_i;

  always_comb begin
    ent_d = ent_q;
    case (cmd_i.op)
      CMD_INIT: begin
        ent_d = '0;
        if (idx_i == '0) begin
          ent_d.size = cmd_i.init_size;
          ent_d.free = 1'b1;
        end
      end
      CMD_TAKE: begin
        if (me == tgt) ent_d.free = 1'b0;
      end
      CMD_SPLIT: begin
        if (me > tgt_nx) begin
          ent_d = left_i;
        end else if (me == tgt_nx) begin
          ent_d.start = cmd_i.new_start;
          ent_d.size  = cmd_i.new_size;
          ent_d.free  = 1'b1;
        end else if (me == tgt) begin
          ent_d.size = cmd_i.need;
          ent_d.free = 1'b0;
        end
      end
      CMD_FREE: begin
        if (me == tgt) ent_d.free = 1'b1;
      end
      CMD_MERGE: begin
        if (me > tgt) begin
          ent_d = right_i;
        end else if (me == tgt) begin
          ent_d.size = ent_q.size + right_i.size + 32'(HDR_BYTES);
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.start <= '0;
      ent_q.size  <= (idx_i == '0) ? RST_BSIZE : '0;
      ent_q.free  <= (idx_i == '0);
    end else begin
      ent_q <= ent_d;
    end
  end

  always_comb begin
    if (key_i.alloc) begin
      hit_o = valid && ent_q.free && ({2'b00, ent_q.size} >= key_i.need);
    end else begin
      hit_o = valid && (key_i.ptr_off[47:32] == '0) && (ent_q.start == key_i.ptr_off[31:0]);
    end
  end

  assign entry_o = ent_q;

endmodule

>>> sv/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: control sequencer and the row of table cells.
//
// The block list lives in a row of 64 cells, one entry each, kept in address order.
// All cells compare the request against their entry in the same cycle. The first
// hit is then picked, and an insert (split) or a removal (merge) moves every entry
// above the target one place along the row. Requests are handled one at a time. An
// allocate passes through the search, pick and update states, and its result is
// loaded on leaving the output state. A free adds two merge steps after the update,
// one toward each neighbor. The input stalls from the accept until the result is
// loaded, so a new request is not taken while one is in progress. A new result
// that finds the previous one still untaken waits in the output step until that
// one is taken.
// Writing heap_base or heap_size re-initializes the table to one free block of
// heap_size minus a 40-byte header (zero if the region is smaller than a header);
// write configuration only while the block is idle.
module first_fit_heap_allocator_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ffha_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ffha_pkg::rsp_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [47:0]    cfg_data_i
);
  import ffha_pkg::*;
  `include "first_fit_heap_allocator_top_defines.svh"

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SRCH = 7'b0000010,
    S_PICK = 7'b0000100,
    S_UPD  = 7'b0001000,
    S_MRG1 = 7'b0010000,
    S_MRG2 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [47:0] base_q;
  logic [31:0] hsize_q;
  logic [31:0] used_q, used_d;
  logic [CNT_W-1:0] count_q;

  logic        op_q, null_q;
  logic [33:0] need_q;
  logic [47:0] ptroff_q;
  logic [MAX_BLOCKS-1:0] hit_q;

  logic             found_q;
  logic [IDX_W-1:0] idx_q;
  logic [31:0]      sel_start_q, sel_size_q;
  logic             sel_free_q;

  logic [47:0] addr_q, addr_d;
  logic [2:0]  status_q, status_d;

  rsp_t res_q;
  logic out_valid_q;

  cmd_t cmd;
  key_t key;

  entry_t ent [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] hits;
  logic [MAX_BLOCKS:0]   free_ext;

  logic in_acc;
  logic [32:0] need_in;
  logic [31:0] cfg_size;

  // Pick stage.
  logic [MAX_BLOCKS-1:0] first;
  logic [IDX_W-1:0]      pk_idx;
  logic [31:0]           pk_start, pk_size;
  logic                  pk_free;

  // Update stage.
  logic        do_split;
  logic [CNT_W-1:0] idx_nx;

  // ---------------------------------------------------------------------------
  // Cell row: each cell sees both neighbours so entries can shift either way.
  // ---------------------------------------------------------------------------
  assign key.alloc   = (op_q == OP_ALLOC);
  assign key.need    = need_q;
  assign key.ptr_off = ptroff_q;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    entry_t left_e, right_e;
    if (g == 0) begin : g_lz
      assign left_e = '0;
    end else begin : g_ln
      assign left_e = ent[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_rz
      assign right_e = '0;
    end else begin : g_rn
      assign right_e = ent[g+1];
    end
    ffha_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .key_i   (key),
      .count_i (count_q),
      .left_i  (left_e),
      .right_i (right_e),
      .entry_o (ent[g]),
      .hit_o   (hits[g])
    );
    assign free_ext[g] = ent[g].free;
  end
  assign free_ext[MAX_BLOCKS] = 1'b0;

  // ---------------------------------------------------------------------------
  // Input side: take a beat only when idle.
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign need_in    = ({1'b0, in_data_i.request_size} + 33'(ALIGN_B - 1))
                      & ~33'(ALIGN_B - 1);
  assign cfg_size   = (cfg_index_i == CFG_HEAP_SIZE) ? cfg_data_i[31:0] : hsize_q;

  // Pick the lowest hit and read its entry.
  always_comb begin
    first    = hit_q & (~hit_q + 1'b1);
    pk_idx   = '0;
    pk_start = '0;
    pk_size  = '0;
    pk_free  = 1'b0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (first[i]) begin
        pk_idx   = pk_idx | IDX_W'(i);
        pk_start = pk_start | ent[i].start;
        pk_size  = pk_size | ent[i].size;
        pk_free  = pk_free | ent[i].free;
      end
    end
  end

  assign do_split = ({2'b00, sel_size_q} >= need_q + 34'(HDR_BYTES + SPLIT_MIN))
                    && (count_q < CNT_W'(MAX_BLOCKS));
  assign idx_nx   = CNT_W'(idx_q) + CNT_W'(1);

  // ---------------------------------------------------------------------------
  // Sequencer and cell commands.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    cmd      = '0;
    cmd.op   = CMD_NONE;
    cmd.idx  = idx_q;
    used_d   = used_q;
    addr_d   = addr_q;
    status_d = status_q;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          cmd.op        = CMD_INIT;
          cmd.init_size = (cfg_size >= 32'(HDR_BYTES)) ? cfg_size - 32'(HDR_BYTES) : '0;
          used_d        = '0;
        end
        if (in_acc) state_d = S_SRCH;
      end
      S_SRCH: state_d = S_PICK;
      S_PICK: state_d = S_UPD;
      S_UPD: begin
        addr_d  = '0;
        state_d = S_OUT;
        if (op_q == OP_ALLOC) begin
          if (null_q) begin
            status_d = ST_NULL;
          end else if (!found_q) begin
            status_d = ST_NOHEAP;
          end else begin
            status_d = ST_OK;
            addr_d   = base_q + 48'(sel_start_q) + 48'(HDR_BYTES);
            if (do_split) begin
              cmd.op        = CMD_SPLIT;
              cmd.need      = need_q[31:0];
              cmd.new_start = sel_start_q + 32'(HDR_BYTES) + need_q[31:0];
              cmd.new_size  = sel_size_q - need_q[31:0] - 32'(HDR_BYTES);
              used_d        = used_q + need_q[31:0];
            end else begin
              cmd.op = CMD_TAKE;
              used_d = used_q + sel_size_q;
            end
          end
        end else begin
          if (null_q) begin
            status_d = ST_NULL;
          end else if (!found_q) begin
            status_d = ST_BAD;
          end else if (sel_free_q) begin
            status_d = ST_DOUBLE;
          end else begin
            status_d = ST_OK;
            cmd.op   = CMD_FREE;
            used_d   = used_q - sel_size_q;
            state_d  = S_MRG1;
          end
        end
      end
      S_MRG1: begin
        // Fold the next block in when it is free.
        if (idx_nx < count_q && free_ext[idx_nx]) cmd.op = CMD_MERGE;
        state_d = S_MRG2;
      end
      S_MRG2: begin
        // Fold this block into the previous one when that is free.
        if (idx_q != '0 && free_ext[CNT_W'(idx_q - IDX_W'(1))]) begin
          cmd.op  = CMD_MERGE;
          cmd.idx = idx_q - IDX_W'(1);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      hsize_q     <= RST_HSIZE;
      used_q      <= '0;
      count_q     <= CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cmd.op == CMD_INIT) begin
        count_q <= CNT_W'(1);
        if (cfg_index_i == CFG_HEAP_BASE) base_q <= cfg_data_i;
        else hsize_q <= cfg_data_i[31:0];
      end else if (cmd.op == CMD_SPLIT) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd.op == CMD_MERGE) begin
        count_q <= count_q - CNT_W'(1);
      end
      // Load the next result on leaving S_OUT; otherwise drop the result once taken.
      if (state_q == S_OUT && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    status_q <= status_d;
    if (in_acc) begin
      op_q     <= in_data_i.operation;
      null_q   <= (in_data_i.operation == OP_ALLOC) ? (in_data_i.request_size == '0)
                                                    : (in_data_i.release_address == '0);
      need_q   <= {1'b0, need_in};
      ptroff_q <= in_data_i.release_address - base_q - 48'(HDR_BYTES);
    end
    if (state_q == S_SRCH) hit_q <= hits;
    if (state_q == S_PICK) begin
      found_q     <= |hit_q;
      idx_q       <= pk_idx;
      sel_start_q <= pk_start;
      sel_size_q  <= pk_size;
      sel_free_q  <= pk_free;
    end
    if (state_q == S_OUT && state_d == S_IDLE) begin
      res_q.address    <= addr_q;
      res_q.status     <= status_q;
      res_q.used_bytes <= used_q;
      res_q.free_bytes <= hsize_q - used_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  `FFHA_ASSERT_IMPL(a_count_range, 1'b1, count_q != '0 && count_q <= CNT_W'(MAX_BLOCKS), "block count out of range")
  `FFHA_ASSERT_IMPL(a_split_room, cmd.op == CMD_SPLIT, count_q < CNT_W'(MAX_BLOCKS), "split with full table")
  `FFHA_ASSERT_IMPL(a_merge_pair, cmd.op == CMD_MERGE, count_q > CNT_W'(1), "merge with a single block")
  `FFHA_ASSERT_NEXT(a_cmd_idle, state_q == S_SRCH, cmd.op == CMD_NONE, "command issued during pick")

endmodule
